// File: hdl/smf_pkg.sv
package smf_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int POSITION_WIDTH = 20;

    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int DIV_STEPS  = GAIN_FRAC;
    localparam int SQRT_STEPS = GAIN_FRAC + 1;
    localparam int SQ_W       = 2 * GAIN_FRAC + 1;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);
    localparam int PROD_W     = SAMPLE_WIDTH + GAIN_W + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [GAIN_W-1:0] UNITY_GAIN  = {1'b1, {GAIN_FRAC{1'b0}}};
    localparam logic [GAIN_W-1:0] SILENT_GAIN = GAIN_W'(655);
    localparam logic [POSITION_WIDTH-1:0] FADE_LENGTH_RESET = POSITION_WIDTH'(4800);

    localparam logic REG_FADE_LENGTH = 1'b0;
    localparam logic REG_FADE_CURVE  = 1'b1;

    typedef enum logic [2:0] {
        ACT_FRAME    = 3'd0,
        ACT_FADE_OUT = 3'd1,
        ACT_FADE_IN  = 3'd2,
        ACT_MUTE     = 3'd3,
        ACT_PLAY     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        MODE_PLAYING  = 2'd0,
        MODE_FADE_OUT = 2'd1,
        MODE_MUTED    = 2'd2,
        MODE_FADE_IN  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_SCALE,
        S_WRITE
    } t_state;

    typedef enum logic [2:0] {
        G_IDLE,
        G_DIV,
        G_POST,
        G_SQ,
        G_SQRT
    } t_gain_state;

    typedef struct packed {
        t_action                  action;
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
        logic [GAIN_W-1:0]        gain;
        t_mode                    mode;
        logic                     transitioning;
        logic                     silent;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic fade_out;
        logic power_curve;
    } t_gain_req;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] gain;
    } t_gain_rsp;

endpackage

// File: hdl/smf_gain_unit.sv
module smf_gain_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smf_pkg::t_gain_req                   i_req,
    input  logic [smf_pkg::POSITION_WIDTH-1:0]   i_pos,
    input  logic [smf_pkg::POSITION_WIDTH-1:0]   i_len,
    output smf_pkg::t_gain_rsp                   o_rsp
);
    import smf_pkg::*;

    localparam logic [SQ_W-1:0] SQRT_BIT_INIT = {1'b1, {(SQ_W-1){1'b0}}};
    localparam logic [SQ_W-1:0] SQ_ROUND = {{(GAIN_FRAC+1){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};

    t_gain_state                r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [POSITION_WIDTH-1:0]  r_rem, n_rem;
    logic [POSITION_WIDTH-1:0]  r_den, n_den;
    logic [GAIN_FRAC-1:0]       r_quo, n_quo;
    logic [SQ_W-1:0]            r_x, n_x;
    logic [SQ_W-1:0]            r_root, n_root;
    logic [SQ_W-1:0]            r_bit, n_bit;
    logic [2*GAIN_FRAC-1:0]     r_sq, n_sq;
    logic                       r_fade_out, n_fade_out;
    logic                       r_power, n_power;
    t_gain_rsp                  r_rsp, n_rsp;

    logic [POSITION_WIDTH:0]    w_shift;
    logic [SQ_W:0]              w_trial;
    logic [SQ_W-1:0]            w_sq_sum;
    logic [GAIN_W-1:0]          w_inv;

    assign o_rsp = r_rsp;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_den      = r_den;
        n_quo      = r_quo;
        n_x        = r_x;
        n_root     = r_root;
        n_bit      = r_bit;
        n_sq       = r_sq;
        n_fade_out = r_fade_out;
        n_power    = r_power;
        n_rsp      = '{done: 1'b0, gain: r_rsp.gain};

        w_shift  = {r_rem, 1'b0};
        w_trial  = {1'b0, r_root} + {1'b0, r_bit};
        w_sq_sum = {1'b0, r_sq} + SQ_ROUND;
        w_inv    = UNITY_GAIN - {1'b0, r_quo};

        case (r_state)
            G_IDLE: begin
                if (i_req.start) begin
                    n_rem      = i_pos;
                    n_den      = i_len;
                    n_quo      = '0;
                    n_cnt      = CNT_W'(DIV_STEPS - 1);
                    n_fade_out = i_req.fade_out;
                    n_power    = i_req.power_curve;
                    n_state    = G_DIV;
                end
            end
            G_DIV: begin
                // restoring division, one quotient bit per cycle
                if (w_shift >= {1'b0, r_den}) begin
                    n_rem = POSITION_WIDTH'(w_shift - {1'b0, r_den});
                    n_quo = {r_quo[GAIN_FRAC-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[POSITION_WIDTH-1:0];
                    n_quo = {r_quo[GAIN_FRAC-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = G_POST;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            G_POST: begin
                if (!r_power) begin
                    n_rsp.done = 1'b1;
                    n_rsp.gain = r_fade_out ? w_inv : {1'b0, r_quo};
                    n_state    = G_IDLE;
                end else if (!r_fade_out) begin
                    n_sq    = r_quo * r_quo;
                    n_state = G_SQ;
                end else begin
                    n_x     = {w_inv, {GAIN_FRAC{1'b0}}};
                    n_root  = '0;
                    n_bit   = SQRT_BIT_INIT;
                    n_cnt   = CNT_W'(SQRT_STEPS - 1);
                    n_state = G_SQRT;
                end
            end
            G_SQ: begin
                n_rsp.done = 1'b1;
                n_rsp.gain = w_sq_sum[2*GAIN_FRAC:GAIN_FRAC];
                n_state    = G_IDLE;
            end
            G_SQRT: begin
                // digit-by-digit square root, one result bit per cycle
                if ({1'b0, r_x} >= w_trial) begin
                    n_x    = r_x - w_trial[SQ_W-1:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_cnt == '0) begin
                    n_rsp.done = 1'b1;
                    n_rsp.gain = n_root[GAIN_W-1:0];
                    n_state    = G_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= G_IDLE;
            r_cnt    <= '0;
            r_rsp    <= '{done: 1'b0, gain: '0};
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rsp    <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_x        <= n_x;
        r_root     <= n_root;
        r_bit      <= n_bit;
        r_sq       <= n_sq;
        r_fade_out <= n_fade_out;
        r_power    <= n_power;
    end

    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.done |-> ($past(r_state) == G_POST || $past(r_state) == G_SQ ||
                        $past(r_state) == G_SQRT))
        else $error("gain done without a finishing step");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.done |-> (r_rsp.gain <= UNITY_GAIN))
        else $error("gain above unity");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == G_IDLE && i_req.start) |=> (r_state == G_DIV))
        else $error("start not taken");

endmodule

// File: hdl/smf_lane.sv
module smf_lane (
    input  logic                                      i_clk,
    input  logic signed [smf_pkg::SAMPLE_WIDTH-1:0]   i_sample,
    input  logic [smf_pkg::GAIN_W-1:0]                i_gain,
    output logic signed [smf_pkg::SAMPLE_WIDTH-1:0]   o_sample
);
    import smf_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND =
        {{(PROD_W-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_sample_ext;
    logic signed [PROD_W-1:0] w_gain_ext;
    logic signed [PROD_W-1:0] w_round;
    logic signed [PROD_W-1:0] w_shift;

    assign w_sample_ext = {{(PROD_W-SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample};
    assign w_gain_ext   = {{(PROD_W-GAIN_W){1'b0}}, i_gain};

    always_ff @(posedge i_clk) begin
        r_prod <= w_sample_ext * w_gain_ext;
    end

    // round half up, then floor shift
    assign w_round  = r_prod + ROUND;
    assign w_shift  = w_round >>> GAIN_FRAC;
    assign o_sample = w_shift[SAMPLE_WIDTH-1:0];

endmodule

// File: hdl/stereo_soft_mute_fader_core.sv
// channel   dir  handshake                    word
// in        in   i_in_valid / o_in_stall      i_in  (t_in_word)
// out       out  o_out_valid / i_out_stall    o_out (t_out_word)
// config    in   psel penable pwrite pready   paddr pwdata prdata
//
// one word in work at a time; o_in_stall is high from accept until its result is registered
// commands and playing, muted or fade-end frames go from accept through S_SCALE and S_WRITE back to S_IDLE
// fading frames also wait in S_GAIN: linear runs the 16-step divider and a post step,
//   square adds a squaring step, square root adds the 17-step root in the gain unit
// a result waiting on i_out_stall holds the next word in its last step
// synchronous active-low reset: playing, position 0, unity gain, length 4800, linear
module stereo_soft_mute_fader_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  smf_pkg::t_in_word              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output smf_pkg::t_out_word             o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smf_pkg::ADDR_W-1:0]     paddr,
    input  logic [smf_pkg::DATA_W-1:0]     pwdata,
    output logic [smf_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import smf_pkg::*;

    t_state                     r_state, n_state;
    t_in_word                   r_item, n_item;
    logic [GAIN_W-1:0]          r_apply, n_apply;
    t_mode                      r_mode, n_mode;
    logic [POSITION_WIDTH-1:0]  r_pos, n_pos;
    logic [GAIN_W-1:0]          r_gain, n_gain;
    logic [POSITION_WIDTH-1:0]  r_len;
    logic                       r_curve;
    t_out_word                  r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    t_gain_req                  w_req;
    t_gain_rsp                  w_rsp;
    logic signed [SAMPLE_WIDTH-1:0] w_left, w_right;
    logic                       w_accept;
    logic                       w_fading;
    logic                       w_fade_end;

    smf_gain_unit u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_pos   (r_pos),
        .i_len   (r_len),
        .o_rsp   (w_rsp)
    );

    smf_lane u_lane_left (
        .i_clk    (i_clk),
        .i_sample (r_item.left_in),
        .i_gain   (r_apply),
        .o_sample (w_left)
    );

    smf_lane u_lane_right (
        .i_clk    (i_clk),
        .i_sample (r_item.right_in),
        .i_gain   (r_apply),
        .o_sample (w_right)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_FADE_CURVE) ? {{(DATA_W-1){1'b0}}, r_curve}
                                                      : {{(DATA_W-POSITION_WIDTH){1'b0}}, r_len};

    assign w_fading   = (r_mode == MODE_FADE_OUT) || (r_mode == MODE_FADE_IN);
    assign w_fade_end = (r_pos >= r_len);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_apply     = r_apply;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_gain      = r_gain;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_req       = '{start: 1'b0, fade_out: (r_mode == MODE_FADE_OUT),
                        power_curve: r_curve};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item  = i_in;
                    n_apply = '0;
                    n_state = S_SCALE;
                    if (i_in.action == ACT_FRAME) begin
                        if (r_mode == MODE_PLAYING) begin
                            n_apply = UNITY_GAIN;
                        end else if (w_fading && w_fade_end) begin
                            n_apply = (r_mode == MODE_FADE_OUT) ? '0 : UNITY_GAIN;
                        end else if (w_fading) begin
                            w_req.start = 1'b1;
                            n_state     = S_GAIN;
                        end
                    end
                end
            end
            S_GAIN: begin
                if (w_rsp.done) begin
                    n_apply = w_rsp.gain;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || !i_out_stall) begin
                    case (r_item.action)
                        ACT_FRAME: begin
                            if (r_mode == MODE_MUTED) begin
                                n_gain = '0;
                            end else if (w_fading) begin
                                n_gain = r_apply;
                                if (w_fade_end) begin
                                    n_mode = (r_mode == MODE_FADE_OUT) ? MODE_MUTED
                                                                       : MODE_PLAYING;
                                end else begin
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        end
                        ACT_FADE_OUT: begin
                            if (r_mode == MODE_PLAYING || r_mode == MODE_FADE_IN) begin
                                n_pos  = '0;
                                n_mode = MODE_FADE_OUT;
                            end
                        end
                        ACT_FADE_IN: begin
                            if (r_mode == MODE_MUTED || r_mode == MODE_FADE_OUT) begin
                                n_pos  = '0;
                                n_mode = MODE_FADE_IN;
                            end
                        end
                        ACT_MUTE: begin
                            n_pos  = '0;
                            n_mode = MODE_MUTED;
                            n_gain = '0;
                        end
                        ACT_PLAY: begin
                            n_pos  = '0;
                            n_mode = MODE_PLAYING;
                            n_gain = UNITY_GAIN;
                        end
                        default: begin
                        end
                    endcase
                    n_out.left_out      = w_left;
                    n_out.right_out     = w_right;
                    n_out.gain          = n_gain;
                    n_out.mode          = n_mode;
                    n_out.transitioning = (n_mode == MODE_FADE_OUT) || (n_mode == MODE_FADE_IN);
                    n_out.silent        = (n_mode == MODE_MUTED) ||
                                          ((n_mode == MODE_FADE_OUT) && (n_gain < SILENT_GAIN));
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PLAYING;
            r_pos       <= '0;
            r_gain      <= UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= FADE_LENGTH_RESET;
            r_curve <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_FADE_LENGTH) begin
                r_len <= pwdata[POSITION_WIDTH-1:0];
            end else begin
                r_curve <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_apply <= n_apply;
        r_out   <= n_out;
    end

    a_muted_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_MUTED) |-> (r_gain == '0))
        else $error("muted with nonzero gain");

    a_gain_unity_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY_GAIN)
        else $error("gain above unity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted word not in work");

    a_rsp_in_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_GAIN))
        else $error("gain result outside gain wait");

endmodule

// File: bench/stereo_soft_mute_fader_core_tb.sv
module stereo_soft_mute_fader_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 600;
    localparam int CALM_AFTER   = 540;
    localparam int DIR_ROWS     = 26;

    localparam t_action ACT_UNK5 = t_action'(3'd5);
    localparam t_action ACT_UNK6 = t_action'(3'd6);
    localparam t_action ACT_UNK7 = t_action'(3'd7);

    localparam logic [SAMPLE_WIDTH-1:0] S_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_NEG1 = '1;
    localparam logic [SAMPLE_WIDTH-1:0] S_ONE  = SAMPLE_WIDTH'(1);
    localparam logic [SAMPLE_WIDTH-1:0] S_ZERO = '0;
    localparam logic [POSITION_WIDTH-1:0] LEN_MAX = '1;

    localparam t_out_word NO_W          = '0;
    localparam t_out_word W_PASS        = '{S_MAX, S_MIN, UNITY_GAIN, MODE_PLAYING, 1'b0, 1'b0};
    localparam t_out_word W_PASS_SWAP   = '{S_MIN, S_MAX, UNITY_GAIN, MODE_PLAYING, 1'b0, 1'b0};
    localparam t_out_word W_PLAY_IDLE   = '{S_ZERO, S_ZERO, UNITY_GAIN, MODE_PLAYING, 1'b0, 1'b0};
    localparam t_out_word W_MUTED       = '{S_ZERO, S_ZERO, 17'd0, MODE_MUTED, 1'b0, 1'b1};
    localparam t_out_word W_OUT_STARTED = '{S_ZERO, S_ZERO, UNITY_GAIN, MODE_FADE_OUT, 1'b1, 1'b0};
    localparam t_out_word W_IN_STARTED  = '{S_ZERO, S_ZERO, 17'd0, MODE_FADE_IN, 1'b1, 1'b0};

    typedef struct packed {
        logic                      cfg;
        logic [POSITION_WIDTH-1:0] len;
        logic                      curve;
        t_action                   act;
        logic [SAMPLE_WIDTH-1:0]   l;
        logic [SAMPLE_WIDTH-1:0]   r;
        logic                      typed;
        t_out_word                 want;
    } t_row;

    localparam t_row STIM_TABLE [0:DIR_ROWS-1] = '{
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b1, W_PASS},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MIN,  S_MAX,  1'b1, W_PASS_SWAP},
        '{1'b0, 20'd0, 1'b0, ACT_FADE_OUT, S_MAX,  S_MAX,  1'b1, W_OUT_STARTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MAX,  1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MIN,  S_NEG1, 1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_FADE_IN,  S_ZERO, S_ZERO, 1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_NEG1, S_ONE,  1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_MUTE,     S_MAX,  S_MIN,  1'b1, W_MUTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b1, W_MUTED},
        '{1'b0, 20'd0, 1'b0, ACT_FADE_OUT, S_ZERO, S_ZERO, 1'b1, W_MUTED},
        '{1'b0, 20'd0, 1'b0, ACT_UNK5,     S_MAX,  S_MIN,  1'b1, W_MUTED},
        '{1'b0, 20'd0, 1'b0, ACT_FADE_IN,  S_ZERO, S_ZERO, 1'b1, W_IN_STARTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_PLAY,     S_ZERO, S_ZERO, 1'b1, W_PLAY_IDLE},
        '{1'b0, 20'd0, 1'b0, ACT_FADE_IN,  S_ZERO, S_ZERO, 1'b1, W_PLAY_IDLE},
        '{1'b0, 20'd0, 1'b0, ACT_UNK6,     S_ZERO, S_ZERO, 1'b1, W_PLAY_IDLE},
        '{1'b0, 20'd0, 1'b0, ACT_UNK7,     S_MAX,  S_MAX,  1'b1, W_PLAY_IDLE},
        '{1'b1, 20'd0, 1'b0, ACT_FADE_OUT, S_ZERO, S_ZERO, 1'b1, W_OUT_STARTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b1, W_MUTED},
        '{1'b1, 20'd1, 1'b1, ACT_FADE_IN,  S_ZERO, S_ZERO, 1'b1, W_IN_STARTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b1, W_PASS},
        '{1'b1, LEN_MAX, 1'b1, ACT_FADE_OUT, S_ZERO, S_ZERO, 1'b1, W_OUT_STARTED},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b0, NO_W},
        '{1'b0, 20'd0, 1'b0, ACT_FRAME,    S_MIN,  S_MAX,  1'b0, NO_W},
        '{1'b1, 20'd2, 1'b0, ACT_FRAME,    S_MAX,  S_MIN,  1'b1, W_MUTED}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // fader state as predicted
    t_mode                     p_mode  = MODE_PLAYING;
    logic [POSITION_WIDTH-1:0] p_pos   = '0;
    logic [GAIN_W-1:0]         p_gain  = UNITY_GAIN;
    logic [POSITION_WIDTH-1:0] p_len   = FADE_LENGTH_RESET;
    logic                      p_curve = 1'b0;

    t_out_word scaled_q[$];
    t_out_word want_w;
    int        err_count   = 0;
    int        cycle_count = 0;
    bit        calm        = 1'b0;
    int        gap_pct     = 0;
    int        stall_pct   = 0;
    int        hold_asks   = 0;
    int        hold_done   = 0;
    int        hold_left   = 0;
    int        stall_left  = 0;

    stereo_soft_mute_fader_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 65537;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic logic [GAIN_W-1:0] ramp_gain(input logic fout);
        longint unsigned q;
        longint unsigned unity;
        unity = longint'(UNITY_GAIN);
        q = {44'd0, p_pos};
        q = (q << GAIN_FRAC) / {44'd0, p_len};
        if (q > unity - 1) q = unity - 1;
        if (!p_curve) begin
            return fout ? GAIN_W'(unity - q) : GAIN_W'(q);
        end
        if (fout) begin
            return GAIN_W'(root_floor((unity - q) << GAIN_FRAC));
        end
        return GAIN_W'((q * q + 32768) >> GAIN_FRAC);
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] apply_gain(
        input logic signed [SAMPLE_WIDTH-1:0] s, input logic [GAIN_W-1:0] g);
        longint acc;
        acc = longint'(s) * longint'({1'b0, g}) + 32768;
        acc = acc >>> GAIN_FRAC;
        return acc[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic t_out_word fader_predict(input t_in_word w);
        t_out_word         o;
        logic [GAIN_W-1:0] g;
        logic              fout;
        o = '0;
        case (w.action)
            ACT_FRAME: begin
                if (p_mode == MODE_PLAYING) begin
                    o.left_out  = w.left_in;
                    o.right_out = w.right_in;
                end else if (p_mode == MODE_MUTED) begin
                    p_gain = '0;
                end else begin
                    fout = (p_mode == MODE_FADE_OUT);
                    if (p_pos >= p_len) begin
                        p_mode = fout ? MODE_MUTED : MODE_PLAYING;
                        g = fout ? '0 : UNITY_GAIN;
                    end else begin
                        g = ramp_gain(fout);
                        p_pos = p_pos + 1'b1;
                    end
                    o.left_out  = apply_gain(w.left_in, g);
                    o.right_out = apply_gain(w.right_in, g);
                    p_gain = g;
                end
            end
            ACT_FADE_OUT: begin
                if (p_mode == MODE_PLAYING || p_mode == MODE_FADE_IN) begin
                    p_pos  = '0;
                    p_mode = MODE_FADE_OUT;
                end
            end
            ACT_FADE_IN: begin
                if (p_mode == MODE_MUTED || p_mode == MODE_FADE_OUT) begin
                    p_pos  = '0;
                    p_mode = MODE_FADE_IN;
                end
            end
            ACT_MUTE: begin
                p_pos  = '0;
                p_mode = MODE_MUTED;
                p_gain = '0;
            end
            ACT_PLAY: begin
                p_pos  = '0;
                p_mode = MODE_PLAYING;
                p_gain = UNITY_GAIN;
            end
            default: ;
        endcase
        o.gain          = p_gain;
        o.mode          = p_mode;
        o.transitioning = (p_mode == MODE_FADE_OUT || p_mode == MODE_FADE_IN);
        o.silent        = (p_mode == MODE_MUTED) ||
                          (p_mode == MODE_FADE_OUT && p_gain < SILENT_GAIN);
        return o;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(15))
            0: return S_MAX;
            1: return S_MIN;
            2: return S_ZERO;
            3: return S_NEG1;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       r;
        r = $urandom_range(99);
        if (r < 70) w.action = ACT_FRAME;
        else if (r < 79) w.action = ACT_FADE_OUT;
        else if (r < 88) w.action = ACT_FADE_IN;
        else if (r < 92) w.action = ACT_MUTE;
        else if (r < 96) w.action = ACT_PLAY;
        else w.action = t_action'(3'($urandom_range(5, 7)));
        w.left_in  = pick_sample();
        w.right_in = pick_sample();
        return w;
    endfunction

    task automatic reg_write(input logic idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_FADE_LENGTH) begin
            p_len = data[POSITION_WIDTH-1:0];
        end else begin
            p_curve = data[0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_fade(input logic [POSITION_WIDTH-1:0] len, input logic curve);
        logic [DATA_W-1:0] d;
        d = $urandom;
        d[POSITION_WIDTH-1:0] = len;
        reg_write(REG_FADE_LENGTH, d);
        d = $urandom;
        d[0] = curve;
        reg_write(REG_FADE_CURVE, d);
    endtask

    task automatic offer_word(input t_in_word w);
        i_in       <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (scaled_q.size() == 0) begin
                    flag_error("word out with nothing pending");
                end else begin
                    want_w = scaled_q.pop_front();
                    cmp_field("left_out", 32'(o_out.left_out), 32'(want_w.left_out));
                    cmp_field("right_out", 32'(o_out.right_out), 32'(want_w.right_out));
                    cmp_field("gain", 32'(o_out.gain), 32'(want_w.gain));
                    cmp_field("mode", 32'(o_out.mode), 32'(want_w.mode));
                    cmp_field("transitioning", 32'(o_out.transitioning),
                              32'(want_w.transitioning));
                    cmp_field("silent", 32'(o_out.silent), 32'(want_w.silent));
                end
            end
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_done != hold_asks) begin
                hold_done   <= hold_done + 1;
                hold_left   <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(99) < stall_pct) begin
                stall_left  <= $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row                      row;
        t_in_word                  w;
        t_out_word                 predicted;
        logic [POSITION_WIDTH-1:0] len;
        int                        words_done;
        int                        phase;
        int                        n;
        int                        r;

        words_done = 0;
        phase = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            row = STIM_TABLE[k];
            if (row.cfg) begin
                settle();
                write_fade(row.len, row.curve);
            end
            w = '{row.act, row.l, row.r};
            offer_word(w);
            predicted = fader_predict(w);
            scaled_q.push_back(row.typed ? row.want : predicted);
        end

        while (words_done < RANDOM_WORDS) begin
            settle();
            r = $urandom_range(99);
            if (r < 8) len = '0;
            else if (r < 16) len = POSITION_WIDTH'(1);
            else if (r < 22) len = LEN_MAX;
            else if (r < 28) len = FADE_LENGTH_RESET;
            else len = POSITION_WIDTH'($urandom_range(2, 32));
            write_fade(len, 1'($urandom_range(1)));
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase
            // long receiver hold while words keep coming
            if (phase == 2) hold_asks++;
            n = $urandom_range(20, 50);
            for (int j = 0; j < n; j++) begin
                if (phase == 4 && j == n / 2) settle();
                w = random_word();
                offer_word(w);
                predicted = fader_predict(w);
                scaled_q.push_back(predicted);
                words_done++;
                if (words_done >= CALM_AFTER) calm = 1'b1;
                if (!calm && $urandom_range(99) < gap_pct) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
            end
            phase++;
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
